// ===== rtl/tsaf_pkg.sv =====
// Shared constants, types and helper functions for the text shadow alpha filter.
package tsaf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int EDGE_BORDER = 5;

   localparam int COORD_W = $clog2(MAX_WIDTH);
   localparam int SIZE_W  = COORD_W + 1;
   localparam int CFG_W   = SIZE_W;
   localparam int PIX_W   = 8;
   localparam int GRAY_W  = 8;
   localparam int IDX_W   = 3;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   // Alpha = floor((20 * axis + diag) / 30), capped at 200.
   localparam int AXIS_WEIGHT = 20;
   localparam int ALPHA_DIV   = 30;
   localparam int ALPHA_CAP   = 200;
   localparam int SAT_LIMIT   = (ALPHA_CAP + 1) * ALPHA_DIV;
   localparam int RECIP_SHIFT = 18;
   localparam int RECIP       = (2 ** RECIP_SHIFT + ALPHA_DIV - 1) / ALPHA_DIV;
   localparam int NSUM_W      = $clog2(4 * 255 * (AXIS_WEIGHT + 1) + 1);
   localparam int DIV_IN_W    = $clog2(SAT_LIMIT);
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int PROD_W      = DIV_IN_W + RECIP_W;
   localparam int WSUM_W      = GRAY_W + 2;

   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [IDX_W-1:0] REG_SHADE_RED    = 3'd2;
   localparam logic [IDX_W-1:0] REG_SHADE_GREEN  = 3'd3;
   localparam logic [IDX_W-1:0] REG_SHADE_BLUE   = 3'd4;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

   // Result slots of one pixel, in emission order.
   localparam int SLOT_MAIN     = 0;
   localparam int SLOT_ROW_END  = 1;
   localparam int SLOT_LAST_ROW = 2;
   localparam int SLOT_CORNER   = 3;
   localparam int NUM_SLOTS     = 4;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic                 interior;
      logic [PIX_W-1:0]     alpha;
      logic [COORD_W-1:0]   xm1;
      logic [COORD_W-1:0]   ym1;
      logic [COORD_W-1:0]   wm1;
      logic [COORD_W-1:0]   hm1;
   } tsaf_entry_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      begin
         if (v < SIZE_W'(2)) begin
            r = SIZE_W'(2);
         end else if (v > hi) begin
            r = hi;
         end else begin
            r = v;
         end
         return r;
      end
   endfunction

   function automatic logic [GRAY_W-1:0] to_gray(input logic [PIX_W-1:0] red,
                                                 input logic [PIX_W-1:0] green,
                                                 input logic [PIX_W-1:0] blue);
      logic [PIX_W+4:0] s;
      begin
         s = (PIX_W+5)'(red) * (PIX_W+5)'(11) + ((PIX_W+5)'(green) << 4)
           + (PIX_W+5)'(blue) * (PIX_W+5)'(5);
         return s[PIX_W+4:5];
      end
   endfunction

endpackage

// ===== rtl/text_shadow_alpha_filter_core.sv =====
// A pixel's beat passes the three front stages and the queue before its result is registered on rsp.
// Throughput: one pixel per cycle while each pixel yields at most one result and rsp is not
// stalled; a pixel that yields several results (row end, last row) holds the single result register
// until all of them are taken, and the eight-entry queue between front and back absorbs those bursts.
// Reset clears position counters, the 3x3 window, pipeline, queue and registers to their
// defaults; the row buffer memory is not cleared and no clearing pass is run.
module text_shadow_alpha_filter_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata, from bit 0: pix_red[7:0], pix_green[7:0], pix_blue[7:0]
   input  logic [tsaf_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata, from bit 0: out_col[9:0], out_row[9:0], out_red[7:0], out_green[7:0],
   // out_blue[7:0], out_alpha[7:0], zero fill[3:0]
   output logic [tsaf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // rsp_tuser, from bit 0: frame_done
   output logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic [tsaf_pkg::IDX_W-1:0]      csr_index,
   input  logic [tsaf_pkg::CFG_W-1:0]      csr_wdata
);
   import tsaf_pkg::*;

   logic [CFG_W-1:0] width_ff, height_ff;
   logic [PIX_W-1:0] red_ff, green_ff, blue_ff;

   logic               push, pop, head_valid;
   tsaf_entry_type     push_entry, head;
   logic [QCNT_W-1:0]  q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         red_ff    <= '0;
         green_ff  <= '0;
         blue_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               width_ff <= csr_wdata;
            end
            REG_FRAME_HEIGHT: begin
               height_ff <= csr_wdata;
            end
            REG_SHADE_RED: begin
               red_ff <= csr_wdata[PIX_W-1:0];
            end
            REG_SHADE_GREEN: begin
               green_ff <= csr_wdata[PIX_W-1:0];
            end
            REG_SHADE_BLUE: begin
               blue_ff <= csr_wdata[PIX_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   tsaf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .q_count    (q_count),
      .push       (push),
      .push_entry (push_entry)
   );

   tsaf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .count      (q_count)
   );

   tsaf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .shade_red   (red_ff),
      .shade_green (green_ff),
      .shade_blue  (blue_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ===== rtl/tsaf_front.sv =====
// Front end: accepts pixels, tracks position, keeps the row buffers and window, computes alpha.
module tsaf_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [tsaf_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [tsaf_pkg::CFG_W-1:0]  cfg_width,
   input  logic [tsaf_pkg::CFG_W-1:0]  cfg_height,
   input  logic [tsaf_pkg::QCNT_W-1:0] q_count,
   output logic                        push,
   output tsaf_pkg::tsaf_entry_type    push_entry
);
   import tsaf_pkg::*;

   localparam int CREDIT_W = QCNT_W + 1;

   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff;
   tsaf_entry_type       s1_meta_ff, s2_meta_ff, s3_meta_ff, s1_meta_in;
   logic [GRAY_W-1:0]    s1_gray_ff;
   logic [NSUM_W-1:0]    s3_sum_ff, s3_sum_in;
   logic [2*GRAY_W-1:0]  rd_ff;
   logic [2*GRAY_W-1:0]  rows_mem [MAX_WIDTH];
   logic [GRAY_W-1:0]    win_ff [9];

   logic [SIZE_W-1:0]  w, h;
   logic [COORD_W-1:0] wm1, hm1, c, r;
   logic               accept;
   logic [CREDIT_W-1:0] used;
   logic [WSUM_W-1:0]  axis, diag;
   logic [PROD_W-1:0]  prod;
   logic [PIX_W-1:0]   alpha;

   assign used = CREDIT_W'(q_count) + CREDIT_W'(s1_valid_ff) + CREDIT_W'(s2_valid_ff)
               + CREDIT_W'(s3_valid_ff);
   assign req_tready = (used < CREDIT_W'(QDEPTH));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      w   = clamp_size(cfg_width, SIZE_W'(MAX_WIDTH));
      h   = clamp_size(cfg_height, SIZE_W'(MAX_HEIGHT));
      wm1 = COORD_W'(w - SIZE_W'(1));
      hm1 = COORD_W'(h - SIZE_W'(1));
      // A size shrunk under a running frame pins the position to the last one.
      c   = (col_ff > wm1) ? wm1 : col_ff;
      r   = (row_ff > hm1) ? hm1 : row_ff;

      s1_meta_in = '0;
      s1_meta_in.mask[SLOT_MAIN]     = (r != '0) && (c != '0);
      s1_meta_in.mask[SLOT_ROW_END]  = (r != '0) && (c == wm1);
      s1_meta_in.mask[SLOT_LAST_ROW] = (r == hm1) && (c != '0);
      s1_meta_in.mask[SLOT_CORNER]   = (r == hm1) && (c == wm1);
      s1_meta_in.interior = (c >= COORD_W'(EDGE_BORDER + 1))
                         && (SIZE_W'(c) + SIZE_W'(EDGE_BORDER - 1) < w)
                         && (r >= COORD_W'(EDGE_BORDER + 1))
                         && (SIZE_W'(r) + SIZE_W'(EDGE_BORDER - 1) < h);
      s1_meta_in.xm1 = c - COORD_W'(1);
      s1_meta_in.ym1 = r - COORD_W'(1);
      s1_meta_in.wm1 = wm1;
      s1_meta_in.hm1 = hm1;

      if (c == wm1) begin
         col_in = '0;
         row_in = (r == hm1) ? '0 : r + COORD_W'(1);
      end else begin
         col_in = c + COORD_W'(1);
         row_in = r;
      end
   end

   // Position counters and the valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage payloads; the front never stalls, credit is taken at the input.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= s1_meta_in;
         s1_gray_ff <= to_gray(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
      end
      s2_meta_ff <= s1_meta_ff;
      s3_meta_ff <= s2_meta_ff;
      s3_sum_ff  <= s3_sum_in;
   end

   // Both gray rows share one word per column: upper byte row r-2, lower byte row r-1.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= rows_mem[c];
      end
      if (s1_valid_ff) begin
         rows_mem[s1_meta_ff.xm1 + COORD_W'(1)] <= {rd_ff[GRAY_W-1:0], s1_gray_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= rd_ff[2*GRAY_W-1:GRAY_W];
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= rd_ff[GRAY_W-1:0];
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= s1_gray_ff;
      end
   end

   always_comb begin
      axis = WSUM_W'(win_ff[1]) + WSUM_W'(win_ff[3]) + WSUM_W'(win_ff[5])
           + WSUM_W'(win_ff[7]);
      diag = WSUM_W'(win_ff[0]) + WSUM_W'(win_ff[2]) + WSUM_W'(win_ff[6])
           + WSUM_W'(win_ff[8]);
      s3_sum_in = NSUM_W'(axis) * NSUM_W'(AXIS_WEIGHT) + NSUM_W'(diag);

      // Below the saturation limit, division by 30 is exact as a reciprocal multiply.
      prod  = PROD_W'(s3_sum_ff[DIV_IN_W-1:0]) * PROD_W'(RECIP);
      alpha = (s3_sum_ff >= NSUM_W'(SAT_LIMIT)) ? PIX_W'(ALPHA_CAP)
                                                 : prod[RECIP_SHIFT +: PIX_W];
   end

   always_comb begin
      push_entry       = s3_meta_ff;
      push_entry.alpha = alpha;
      push             = s3_valid_ff && (s3_meta_ff.mask != '0);
   end

`ifndef ASSERT_OFF
   a_credit_covers_flight: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (q_count + QCNT_W'(s1_valid_ff) + QCNT_W'(s2_valid_ff)
                      + QCNT_W'(s3_valid_ff)) < QCNT_W'(QDEPTH))
      else $error("front accepted without queue space for every item in flight");
`endif

endmodule

// ===== rtl/tsaf_queue.sv =====
// Short queue of classified pixels between the front end and the result sequencer.
module tsaf_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  tsaf_pkg::tsaf_entry_type    push_entry,
   input  logic                        pop,
   output logic                        head_valid,
   output tsaf_pkg::tsaf_entry_type    head,
   output logic [tsaf_pkg::QCNT_W-1:0] count
);
   import tsaf_pkg::*;

   tsaf_entry_type      entries_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head       = entries_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign count      = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < QCNT_W'(QDEPTH))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");
`endif

endmodule

// ===== rtl/tsaf_back.sv =====
// Back end: walks the result slots of each queued pixel and drives the result register.
module tsaf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  tsaf_pkg::tsaf_entry_type    head,
   output logic                        pop,
   input  logic [tsaf_pkg::PIX_W-1:0]  shade_red,
   input  logic [tsaf_pkg::PIX_W-1:0]  shade_green,
   input  logic [tsaf_pkg::PIX_W-1:0]  shade_blue,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tsaf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tuser
);
   import tsaf_pkg::*;

   logic [NUM_SLOTS-1:0]  done_ff, done_in;
   logic [NUM_SLOTS-1:0]  rem, low;
   logic                  more, load, interior;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_user_ff;
   logic [COORD_W-1:0]    x, y;

   always_comb begin
      rem  = head.mask & ~done_ff;
      low  = rem & (~rem + NUM_SLOTS'(1));
      more = |(rem & ~low);
      load = head_valid && (!rsp_valid_ff || rsp_tready);
      pop  = load && !more;

      x = (low[SLOT_MAIN] || low[SLOT_LAST_ROW]) ? head.xm1 : head.wm1;
      y = (low[SLOT_MAIN] || low[SLOT_ROW_END])  ? head.ym1 : head.hm1;
      interior = low[SLOT_MAIN] && head.interior;

      rsp_data_in = {(RSP_DATA_W - 2*COORD_W - 4*PIX_W)'(0),
                     interior ? head.alpha : PIX_W'(0),
                     interior ? shade_blue : PIX_W'(0),
                     interior ? shade_green : PIX_W'(0),
                     interior ? shade_red : PIX_W'(0),
                     y, x};

      done_in = done_ff;
      if (pop) begin
         done_in = '0;
      end else if (load) begin
         done_in = done_ff | low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= !more;
         rsp_user_ff <= low[SLOT_CORNER];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef ASSERT_OFF
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff |-> rsp_last_ff)
      else $error("frame end beat is not the last beat of its pixel");
`endif

endmodule
